// ===== design/lrl_pkg.sv =====
// Package for the LRU recency list: field widths, codes, and the
// command/status structs between controller and datapath. No dependencies.
package lrl_pkg;

	localparam int ID_W          = 32;
	localparam int POS_W         = 32;
	localparam int CAP_CFG_W     = 5;
	localparam int COUNT_W       = 5;
	localparam int DEPTH_DEFAULT = 16;

	localparam logic [CAP_CFG_W-1:0] CAP_RESET = CAP_CFG_W'(16);

	// Remainder unit retires this many dividend bits per cycle while it steps.
	localparam int MOD_BITS  = 8;
	localparam int MOD_STEPS = POS_W / MOD_BITS;
	localparam int STEP_W    = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

	localparam logic FUNC_PUT = 1'b0;
	localparam logic FUNC_GET = 1'b1;

	typedef enum logic [1:0] {
		ST_PUT_NEW = 2'd0,
		ST_PUT_HIT = 2'd1,
		ST_GET_OK  = 2'd2,
		ST_GET_OOR = 2'd3
	} lrl_status_t;

	typedef struct packed {
		logic load;      // capture request, seed remainder unit
		logic mod_step;  // advance remainder unit
		logic compare;   // register match vector
		logic encode;    // register first match
		logic commit;    // update list, load result register
	} lrl_cmd_t;

	typedef struct packed {
		logic is_get;
	} lrl_sts_t;

endpackage

// ===== design/lrl_mod.sv =====
// Iterative remainder unit: dividend modulo a small divisor, MOD_BITS
// dividend bits per step. Depends on lrl_pkg.
module lrl_mod import lrl_pkg::*; #(
	parameter int REM_W = 5
) (
	input  logic             clk,
	input  logic             load,
	input  logic             step,
	input  logic [POS_W-1:0] dividend,
	input  logic [REM_W-1:0] divisor,
	output logic [REM_W-1:0] rem
);

	logic [POS_W-1:0] dvd_q;
	logic [REM_W-1:0] rem_q;
	logic [POS_W-1:0] dvd_nx;
	logic [REM_W-1:0] rem_nx;

	// remainder stays below divisor, so the trial value fits REM_W+1 bits
	always_comb begin
		logic [REM_W:0] t;
		dvd_nx = dvd_q;
		rem_nx = rem_q;
		for (int k = 0; k < MOD_BITS; k++) begin
			t = {rem_nx, dvd_nx[POS_W-1]};
			dvd_nx = {dvd_nx[POS_W-2:0], 1'b0};
			if (t >= {1'b0, divisor}) begin
				t = t - {1'b0, divisor};
			end
			rem_nx = t[REM_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (step) begin
			dvd_q <= dvd_nx;
			rem_q <= rem_nx;
		end
	end

	assign rem = rem_q;

endmodule

// ===== design/lrl_dp.sv =====
// Datapath of the LRU recency list: slot shift line, match vector,
// remainder unit, occupancy, capacity and result register. Depends on lrl_pkg, lrl_mod.
module lrl_dp import lrl_pkg::*; #(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lrl_cmd_t             cmd,
	output lrl_sts_t             sts,
	input  logic                 cfg_wr_en,
	input  logic [CAP_CFG_W-1:0] cfg_wr_data,
	input  logic                 func,
	input  logic [ID_W-1:0]      item_id,
	input  logic [POS_W-1:0]     position,
	output logic [1:0]           status,
	output logic [ID_W-1:0]      read_id,
	output logic                 evicted,
	output logic [ID_W-1:0]      evicted_id,
	output logic [COUNT_W-1:0]   entry_count
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [ID_W-1:0]      slots_q [DEPTH];
	logic [CNT_W-1:0]     occ_q;
	logic [CAP_CFG_W-1:0] cap_q;
	logic                 func_q;
	logic [ID_W-1:0]      id_q;
	logic [DEPTH-1:0]     match_q;
	logic                 hit_q;
	logic [IDX_W-1:0]     where_q;

	logic [1:0]           status_q;
	logic [ID_W-1:0]      read_id_q;
	logic                 evicted_q;
	logic [ID_W-1:0]      evicted_id_q;
	logic [COUNT_W-1:0]   count_q;

	logic [CNT_W-1:0]     cap_eff;
	logic [CNT_W-1:0]     rem;
	logic [IDX_W-1:0]     first_idx;
	logic                 is_get;
	logic                 full;
	logic                 get_ok;
	logic [IDX_W-1:0]     rd_idx;
	logic [ID_W-1:0]      rd_data;
	logic                 move_en;
	logic [IDX_W-1:0]     move_pos;
	logic [ID_W-1:0]      head_val;
	logic [CNT_W-1:0]     occ_nx;
	logic [1:0]           status_nx;
	logic                 evict_nx;

	// capacity clamped to 1..DEPTH
	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CNT_W'(1);
		end else if (32'(cap_q) > 32'(DEPTH)) begin
			cap_eff = CNT_W'(DEPTH);
		end else begin
			cap_eff = CNT_W'(cap_q);
		end
	end

	lrl_mod #(.REM_W(CNT_W)) u_mod (
		.clk      (clk),
		.load     (cmd.load),
		.step     (cmd.mod_step),
		.dividend (position),
		.divisor  (cap_eff),
		.rem      (rem)
	);

	// lowest matching slot wins
	always_comb begin
		first_idx = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (match_q[i]) begin
				first_idx = IDX_W'(i);
			end
		end
	end

	assign is_get = (func_q == FUNC_GET);
	assign full   = (occ_q >= cap_eff);
	assign get_ok = (rem < occ_q);

	// single read port into the slot line
	always_comb begin
		priority if (is_get) begin
			rd_idx = IDX_W'(rem);
		end else if (hit_q) begin
			rd_idx = where_q;
		end else begin
			rd_idx = IDX_W'(occ_q - CNT_W'(1));
		end
	end
	assign rd_data = slots_q[rd_idx];

	always_comb begin
		move_en   = 1'b1;
		move_pos  = rd_idx;
		head_val  = rd_data;
		occ_nx    = occ_q;
		evict_nx  = 1'b0;
		status_nx = ST_PUT_NEW;
		priority if (is_get) begin
			status_nx = get_ok ? ST_GET_OK : ST_GET_OOR;
			move_en   = get_ok;
		end else if (hit_q) begin
			status_nx = ST_PUT_HIT;
		end else begin
			head_val = id_q;
			if (full) begin
				evict_nx = 1'b1;
			end else begin
				move_pos = IDX_W'(occ_q);
				occ_nx   = occ_q + CNT_W'(1);
			end
		end
	end

	assign sts.is_get = func_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			id_q   <= item_id;
		end
		if (cmd.compare) begin
			for (int i = 0; i < DEPTH; i++) begin
				match_q[i] <= (slots_q[i] == id_q) && (CNT_W'(i) < occ_q);
			end
		end
		if (cmd.encode) begin
			hit_q   <= |match_q;
			where_q <= first_idx;
		end
		if (cmd.commit && move_en) begin
			slots_q[0] <= head_val;
			for (int i = 1; i < DEPTH; i++) begin
				if (IDX_W'(i) <= move_pos) begin
					slots_q[i] <= slots_q[i-1];
				end
			end
		end
		if (cmd.commit) begin
			status_q     <= status_nx;
			read_id_q    <= (is_get && get_ok) ? rd_data : '0;
			evicted_q    <= evict_nx;
			evicted_id_q <= evict_nx ? rd_data : '0;
			count_q      <= COUNT_W'(occ_nx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
			occ_q <= '0;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
			occ_q <= '0;
		end else if (cmd.commit) begin
			occ_q <= occ_nx;
		end
	end

	assign status      = status_q;
	assign read_id     = read_id_q;
	assign evicted     = evicted_q;
	assign evicted_id  = evicted_id_q;
	assign entry_count = count_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= cap_eff)
		else $error("occupancy above capacity");

	a_put_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && !is_get |=> count_q != '0 || 32'(DEPTH) > 32'd31)
		else $error("list empty after put");

endmodule

// ===== design/lrl_ctrl.sv =====
// Controller of the LRU recency list: request sequencing, remainder step
// count and result valid. Depends on lrl_pkg.
module lrl_ctrl import lrl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  lrl_sts_t sts,
	output lrl_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CMP,
		S_ENC,
		S_MOD,
		S_COMMIT
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;

	always_comb begin
		cmd.load     = (state_q == S_IDLE) && in_valid;
		cmd.mod_step = (state_q == S_CMP) || (state_q == S_MOD);
		cmd.compare  = (state_q == S_CMP);
		cmd.encode   = (state_q == S_ENC);
		cmd.commit   = (state_q == S_COMMIT) && (!out_valid_q || !out_stall);
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_CMP;
						step_q  <= '0;
					end
				end
				S_CMP: begin
					step_q  <= STEP_W'(1);
					state_q <= sts.is_get ? S_MOD : S_ENC;
				end
				S_ENC: begin
					state_q <= S_COMMIT;
				end
				S_MOD: begin
					if (step_q == STEP_W'(MOD_STEPS - 1)) begin
						state_q <= S_COMMIT;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				S_COMMIT: begin
					if (cmd.commit) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_busy_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> in_stall)
		else $error("request taken while busy");

	a_mod_only_get: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MOD |-> sts.is_get)
		else $error("put entered remainder loop");

endmodule

// ===== design/lru_recency_list_top.sv =====
// Top level of the LRU recency list: controller plus datapath.
// Depends on lrl_pkg, lrl_ctrl, lrl_dp.
//
// Keeps up to list_capacity 32-bit ids, most recent first.
// Input channel (in_valid/in_stall): a request is func, item_id and
//   position, taken at an edge with in_valid high and in_stall low.
//   func put inserts or refreshes item_id; func get reads the entry at
//   position modulo capacity and moves it to the head.
// Output channel (out_valid/out_stall): one result per request, held in
//   a result register until taken.
// Sequence: after a request is taken, a put passes the slot compare
//   state and then the priority encode state; a get passes the compare
//   state and the remainder loop, 8 position bits per cycle over 32
//   bits. Both end in the commit state, which loads the result register;
//   the next request is taken in the cycle after the result is loaded.
// A stalled receiver holds the finished result; a new request is still
//   taken, but its result waits in the final state until the register frees.
// Reset clears occupancy and sets capacity to 16; slot contents are left
//   as they are and are never read past the occupancy.
// cfg_wr_en writes capacity and empties the list; write only when idle.
module lru_recency_list_top import lrl_pkg::*; #(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CAP_CFG_W-1:0] cfg_wr_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 func,
	input  logic [ID_W-1:0]      item_id,
	input  logic [POS_W-1:0]     position,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           status,
	output logic [ID_W-1:0]      read_id,
	output logic                 evicted,
	output logic [ID_W-1:0]      evicted_id,
	output logic [COUNT_W-1:0]   entry_count
);

	lrl_cmd_t cmd;
	lrl_sts_t sts;

	lrl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	lrl_dp #(.DEPTH(DEPTH)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.func        (func),
		.item_id     (item_id),
		.position    (position),
		.status      (status),
		.read_id     (read_id),
		.evicted     (evicted),
		.evicted_id  (evicted_id),
		.entry_count (entry_count)
	);

endmodule
